// File: hdl/swat_pkg.sv
// Shared types, field widths and codes for the sensor window average table.
package swat_pkg;

   localparam int SLOT_FIELD_W = 3;
   localparam int ID_W         = 16;
   localparam int TEMP_W       = 16;
   localparam int TIME_W       = 32;

   localparam int REQ_SLOT_LO  = 0;
   localparam int REQ_SID_LO   = REQ_SLOT_LO + SLOT_FIELD_W;
   localparam int REQ_RID_LO   = REQ_SID_LO + ID_W;
   localparam int REQ_TEMP_LO  = REQ_RID_LO + ID_W;
   localparam int REQ_TIME_LO  = REQ_TEMP_LO + TEMP_W;
   localparam int REQ_USED_W   = REQ_TIME_LO + TIME_W;
   localparam int REQ_DATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   localparam int RSP_ROOM_LO  = 0;
   localparam int RSP_AVG_LO   = RSP_ROOM_LO + ID_W;
   localparam int RSP_TIME_LO  = RSP_AVG_LO + TEMP_W;
   localparam int RSP_USED_W   = RSP_TIME_LO + TIME_W;
   localparam int RSP_DATA_W   = ((RSP_USED_W + 7) / 8) * 8;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SLOT = 4'b0010,
      ST_SUM  = 4'b0100,
      ST_DIV  = 4'b1000
   } state_type;

endpackage

// File: hdl/sensor_window_average_table.sv
// Top level: per-slot state memory, sample ring memory and the item sequencer.
// A map load or an unknown id is answered after the slot read step; a matched sample passes
// through the slot read, ring read and divide steps, and the result waits while the output is stalled.
// One item is in work at a time: a new beat is taken only once the last result is registered.
// Synchronous reset empties the table; per-slot valid bits make every slot read as zero.
module sensor_window_average_table import swat_pkg::*; #(
   parameter int SLOTS  = 8,
   parameter int WINDOW = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // slot, sensor, room, temperature, timestamp, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // room_id_out, average, last_time
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // found
   output logic                  rsp_tuser
);

   localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int WPW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W = TEMP_W + $clog2(WINDOW);
   localparam int DEPTH = SLOTS * WINDOW;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef struct packed {
      logic [ID_W-1:0]   room;
      logic [TIME_W-1:0] last_time;
      logic [SUM_W-1:0]  sum;
      logic [WPW-1:0]    wpos;
      logic              full;
   } slot_entry_type;

   state_type state_ff, state_in;

   logic              kind_ff, kind_in;
   logic              slot_ok_ff, slot_ok_in;
   logic [ID_W-1:0]   sid_ff, sid_in;
   logic [ID_W-1:0]   rid_ff, rid_in;
   logic [TEMP_W-1:0] temp_ff, temp_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic              hit_ff, hit_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     addr_ff, addr_in;
   slot_entry_type    entry_ff, entry_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   slot_entry_type    slot_mem [SLOTS];
   slot_entry_type    slot_rd_ff;
   logic              slot_rv_ff;
   logic              slot_vld_ff [SLOTS];
   logic              slot_rd_en, slot_we;
   logic [IW-1:0]     slot_rd_idx, slot_wr_idx;
   slot_entry_type    slot_wr_data;

   logic [TEMP_W-1:0] smp_mem [DEPTH];
   logic [TEMP_W-1:0] smp_rd_ff;
   logic              smp_rd_en, smp_we;

   logic              accept, out_free;
   logic              hit;
   logic [IW-1:0]     hit_idx;
   logic              id_we;
   logic              div_load;
   logic signed [TEMP_W-1:0] quotient;
   slot_entry_type    entry_cur;
   logic [TEMP_W-1:0] old_smp;
   logic signed [SUM_W-1:0] new_sum;
   logic [WPW-1:0]    wpos_next;

   swat_match #(.SLOTS(SLOTS), .IDX_W(IW)) u_match (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (id_we),
      .wr_idx  (idx_ff),
      .wr_id   (sid_ff),
      .look_id (req_tdata[REQ_SID_LO +: ID_W]),
      .hit     (hit),
      .hit_idx (hit_idx)
   );

   swat_divide #(.SUM_W(SUM_W), .DIVISOR(WINDOW)) u_divide (
      .clock    (clock),
      .load     (div_load),
      .sum_in   (new_sum),
      .quotient (quotient)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;

   assign entry_cur = slot_rv_ff ? slot_rd_ff : '0;
   assign old_smp   = entry_ff.full ? smp_rd_ff : '0;
   assign new_sum   = $signed(entry_ff.sum) - SUM_W'($signed(old_smp))
                      + SUM_W'($signed(temp_ff));
   assign wpos_next = (entry_ff.wpos == WPW'(WINDOW - 1)) ? '0 : entry_ff.wpos + 1'b1;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      slot_ok_in   = slot_ok_ff;
      sid_in       = sid_ff;
      rid_in       = rid_ff;
      temp_in      = temp_ff;
      time_in      = time_ff;
      hit_in       = hit_ff;
      idx_in       = idx_ff;
      addr_in      = addr_ff;
      entry_in     = entry_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_data_in  = rsp_data_ff;
      slot_rd_en   = 1'b0;
      slot_rd_idx  = hit_idx;
      slot_we      = 1'b0;
      slot_wr_idx  = idx_ff;
      slot_wr_data = '0;
      smp_rd_en    = 1'b0;
      smp_we       = 1'b0;
      id_we        = 1'b0;
      div_load     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in    = req_tuser;
               slot_ok_in = int'(req_tdata[REQ_SLOT_LO +: SLOT_FIELD_W]) < SLOTS;
               sid_in     = req_tdata[REQ_SID_LO +: ID_W];
               rid_in     = req_tdata[REQ_RID_LO +: ID_W];
               temp_in    = req_tdata[REQ_TEMP_LO +: TEMP_W];
               time_in    = req_tdata[REQ_TIME_LO +: TIME_W];
               hit_in     = hit;
               idx_in     = (req_tuser == KIND_LOAD)
                            ? IW'(req_tdata[REQ_SLOT_LO +: SLOT_FIELD_W]) : hit_idx;
               slot_rd_en = 1'b1;
               state_in   = ST_SLOT;
            end
         end
         ST_SLOT: begin
            if (kind_ff == KIND_LOAD) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = slot_ok_ff;
                  rsp_data_in  = '0;
                  if (slot_ok_ff) begin
                     rsp_data_in[RSP_ROOM_LO +: ID_W] = rid_ff;
                     slot_we           = 1'b1;
                     slot_wr_data.room = rid_ff;
                     id_we             = 1'b1;
                  end
                  state_in = ST_IDLE;
               end
            end else if (!hit_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  rsp_data_in  = '0;
                  state_in     = ST_IDLE;
               end
            end else begin
               entry_in  = entry_cur;
               addr_in   = AW'(AW'(idx_ff) * AW'(WINDOW)) + AW'(entry_cur.wpos);
               smp_rd_en = 1'b1;
               state_in  = ST_SUM;
            end
         end
         ST_SUM: begin
            smp_we                 = 1'b1;
            slot_we                = 1'b1;
            slot_wr_data.room      = entry_ff.room;
            slot_wr_data.last_time = time_ff;
            slot_wr_data.sum       = new_sum;
            slot_wr_data.wpos      = wpos_next;
            slot_wr_data.full      = entry_ff.full || (entry_ff.wpos == WPW'(WINDOW - 1));
            div_load               = 1'b1;
            state_in               = ST_DIV;
         end
         ST_DIV: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[RSP_ROOM_LO +: ID_W]   = entry_ff.room;
               rsp_data_in[RSP_AVG_LO +: TEMP_W]  = quotient;
               rsp_data_in[RSP_TIME_LO +: TIME_W] = time_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      slot_ok_ff   <= slot_ok_in;
      sid_ff       <= sid_in;
      rid_ff       <= rid_in;
      temp_ff      <= temp_in;
      time_ff      <= time_in;
      hit_ff       <= hit_in;
      idx_ff       <= idx_in;
      addr_ff      <= addr_in;
      entry_ff     <= entry_in;
      rsp_found_ff <= rsp_found_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (reset) begin
            slot_vld_ff[i] <= 1'b0;
         end else if (slot_we && (slot_wr_idx == IW'(i))) begin
            slot_vld_ff[i] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wr_idx] <= slot_wr_data;
      end
      if (slot_rd_en) begin
         slot_rd_ff <= slot_mem[slot_rd_idx];
         slot_rv_ff <= slot_vld_ff[slot_rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (smp_we) begin
         smp_mem[addr_ff] <= temp_ff;
      end
      if (smp_rd_en) begin
         smp_rd_ff <= smp_mem[addr_in];
      end
   end

endmodule

// File: hdl/swat_match.sv
// Sensor id registers with a parallel lookup that returns the lowest matching slot.
module swat_match import swat_pkg::*; #(
   parameter int SLOTS = 8,
   parameter int IDX_W = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [ID_W-1:0]  wr_id,
   input  logic [ID_W-1:0]  look_id,
   output logic             hit,
   output logic [IDX_W-1:0] hit_idx
);

   logic [ID_W-1:0] ids_ff [SLOTS];
   logic [ID_W-1:0] ids_in [SLOTS];

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         ids_in[i] = ids_ff[i];
      end
      if (wr_en) begin
         ids_in[wr_idx] = wr_id;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (reset) begin
            ids_ff[i] <= '0;
         end else begin
            ids_ff[i] <= ids_in[i];
         end
      end
   end

   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (ids_ff[i] == look_id) begin
            hit     = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

endmodule

// File: hdl/swat_divide.sv
// Signed division of the window sum by a constant through a reciprocal multiply.
module swat_divide import swat_pkg::*; #(
   parameter int SUM_W   = 19,
   parameter int DIVISOR = 5
) (
   input  logic                     clock,
   input  logic                     load,
   input  logic signed [SUM_W-1:0]  sum_in,
   output logic signed [TEMP_W-1:0] quotient
);

   localparam int    LOG_D   = $clog2(DIVISOR);
   localparam int    SHIFT   = SUM_W + LOG_D;
   localparam int    RECIP_W = SUM_W + 1;
   localparam int    PROD_W  = SUM_W + RECIP_W;
   localparam longint RECIP_L = (longint'(1) << SHIFT) / DIVISOR + 1;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   logic             neg_ff, neg_in;
   logic [SUM_W-1:0] mag_ff, mag_in;
   logic [PROD_W-1:0] prod;
   logic [TEMP_W-1:0] quot_mag;

   always_comb begin
      neg_in = neg_ff;
      mag_in = mag_ff;
      if (load) begin
         neg_in = sum_in[SUM_W-1];
         mag_in = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
   end

   assign prod     = PROD_W'(mag_ff) * PROD_W'(RECIP);
   assign quot_mag = TEMP_W'(prod >> SHIFT);
   assign quotient = neg_ff ? $signed(-quot_mag) : $signed(quot_mag);

endmodule

// File: dv/sensor_window_average_table_tb.sv
// Self-checking testbench for the sensor window average table with random stream stalls.
`timescale 1ns / 1ps

module sensor_window_average_table_tb import swat_pkg::*;;

   localparam int SLOT_COUNT    = 8;
   localparam int WINDOW_LEN    = 5;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int PAUSE_AT      = 900;
   localparam int HOLD_AT       = 400;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 20;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic                    kind;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [ID_W-1:0]         sensor;
      logic [ID_W-1:0]         room;
      logic [TEMP_W-1:0]       temp;
      logic [TIME_W-1:0]       stamp;
   } reading_in_type;

   typedef struct packed {
      logic              found;
      logic [ID_W-1:0]   room;
      logic [TEMP_W-1:0] avg;
      logic [TIME_W-1:0] stamp;
   } reading_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   logic [ID_W-1:0]          slot_sensor [SLOT_COUNT];
   logic [ID_W-1:0]          slot_room   [SLOT_COUNT];
   logic signed [TEMP_W-1:0] ring_samples [SLOT_COUNT][WINDOW_LEN];
   int                       ring_pos    [SLOT_COUNT];
   logic [TIME_W-1:0]        slot_stamp  [SLOT_COUNT];

   reading_in_type  table_rows [$];
   bit              row_typed  [$];
   reading_out_type row_result [$];
   reading_out_type predicted_reports [$];

   int report_errors = 0;
   int cycle_count   = 0;

   sensor_window_average_table #(
      .SLOTS  (SLOT_COUNT),
      .WINDOW (WINDOW_LEN)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever begin
         #10 clock = ~clock;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   function automatic reading_out_type update_sensor_table(input reading_in_type rd);
      reading_out_type res;
      int              hit;
      int              s;
      int              k;
      int              total;
      res = '0;
      hit = -1;
      if (rd.kind == KIND_LOAD) begin
         slot_sensor[rd.slot] = rd.sensor;
         slot_room[rd.slot]   = rd.room;
         for (k = 0; k < WINDOW_LEN; k++) ring_samples[rd.slot][k] = '0;
         ring_pos[rd.slot]   = 0;
         slot_stamp[rd.slot] = '0;
         res.found = 1'b1;
         res.room  = rd.room;
         return res;
      end
      for (s = SLOT_COUNT - 1; s >= 0; s--) begin
         if (slot_sensor[s] == rd.sensor) hit = s;
      end
      if (hit < 0) return res;
      ring_samples[hit][ring_pos[hit]] = rd.temp;
      ring_pos[hit]   = (ring_pos[hit] + 1) % WINDOW_LEN;
      slot_stamp[hit] = rd.stamp;
      total = 0;
      for (k = 0; k < WINDOW_LEN; k++) total = total + ring_samples[hit][k];
      total = total / WINDOW_LEN;
      res.found = 1'b1;
      res.room  = slot_room[hit];
      res.avg   = total[TEMP_W-1:0];
      res.stamp = slot_stamp[hit];
      return res;
   endfunction

   task automatic add_row(input logic kind, input int slot, input int sensor, input int room,
                          input int temp, input logic [TIME_W-1:0] stamp, input bit typed,
                          input reading_out_type res);
      reading_in_type rd;
      rd.kind   = kind;
      rd.slot   = slot[SLOT_FIELD_W-1:0];
      rd.sensor = sensor[ID_W-1:0];
      rd.room   = room[ID_W-1:0];
      rd.temp   = temp[TEMP_W-1:0];
      rd.stamp  = stamp;
      table_rows.push_back(rd);
      row_typed.push_back(typed);
      row_result.push_back(res);
   endtask

   always @(posedge clock) begin
      reading_out_type want;
      reading_out_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.found = rsp_tuser;
         got.room  = rsp_tdata[RSP_ROOM_LO +: ID_W];
         got.avg   = rsp_tdata[RSP_AVG_LO +: TEMP_W];
         got.stamp = rsp_tdata[RSP_TIME_LO +: TIME_W];
         if (predicted_reports.size() == 0) begin
            report_errors++;
            if (report_errors <= REPORT_LIMIT)
               $display("unexpected beat: found=%0d room=%h avg=%h time=%h",
                        got.found, got.room, got.avg, got.stamp);
         end else begin
            want = predicted_reports.pop_front();
            if (want.found !== got.found || want.room !== got.room ||
                want.avg !== got.avg || want.stamp !== got.stamp) begin
               report_errors++;
               if (report_errors <= REPORT_LIMIT)
                  $display("mismatch: expected %0d/%h/%h/%h, actual %0d/%h/%h/%h",
                           want.found, want.room, want.avg, want.stamp,
                           got.found, got.room, got.avg, got.stamp);
            end
         end
      end
   end

   initial begin
      int   stall;
      int   taken;
      logic recv_burst;
      taken = 0;
      recv_burst = 1'b0;
      rsp_tready <= 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
         stall = recv_burst ? 0 : $urandom_range(0, 19);
         if (taken == HOLD_AT) stall = HOLD_CYCLES;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      reading_in_type        rd;
      reading_out_type       res;
      logic [REQ_DATA_W-1:0] word;
      int                    n;
      int                    gap;
      int                    pick;
      logic                  send_burst;

      for (n = 0; n < SLOT_COUNT; n++) begin
         slot_sensor[n] = '0;
         slot_room[n]   = '0;
         for (gap = 0; gap < WINDOW_LEN; gap++) ring_samples[n][gap] = '0;
         ring_pos[n]    = 0;
         slot_stamp[n]  = '0;
      end

      // Right after reset every slot holds id zero, so id zero hits slot 0.
      add_row(KIND_SAMPLE, 7, 'h0000, 'hFFFF, 'h7FFF, 32'hFFFF_FFFF, 1,
              {1'b1, 16'h0000, 16'h1999, 32'hFFFF_FFFF});
      add_row(KIND_LOAD, 0, 'hFFFF, 'hFFFF, 'hFFFF, 32'hFFFF_FFFF, 1,
              {1'b1, 16'hFFFF, 16'h0000, 32'h0000_0000});
      add_row(KIND_LOAD, 7, 'h1234, 'hA5A5, 'h8000, 32'h1234_5678, 1,
              {1'b1, 16'hA5A5, 16'h0000, 32'h0000_0000});
      add_row(KIND_SAMPLE, 7, 'h5555, 'hFFFF, 'h7FFF, 32'hFFFF_FFFF, 1, '0);
      for (n = 1; n <= WINDOW_LEN; n++)
         add_row(KIND_SAMPLE, 5, 'hFFFF, 'h3C3C, 'h8000, n, 0, '0);
      add_row(KIND_SAMPLE, 2, 'hFFFF, 'h0000, 'h7FFF, 32'h0000_0000, 0, '0);
      add_row(KIND_SAMPLE, 0, 'hFFFF, 'h0000, 'hFFFF, 32'h8000_0000, 0, '0);
      add_row(KIND_SAMPLE, 0, 'h1234, 'h0000, 'h0001, 32'h0000_0042, 0, '0);
      add_row(KIND_LOAD, 3, 'h1234, 'h0303, 'h7FFF, 32'hFFFF_FFFF, 1,
              {1'b1, 16'h0303, 16'h0000, 32'h0000_0000});
      add_row(KIND_SAMPLE, 0, 'h1234, 'h0000, 'hFFFF, 32'h0000_0100, 0, '0);
      add_row(KIND_SAMPLE, 0, 'h0000, 'h0000, 'hFFFB, 32'h0000_0200, 0, '0);
      add_row(KIND_SAMPLE, 0, 'h0000, 'h0000, 'hFFFC, 32'h0000_0300, 0, '0);
      add_row(KIND_LOAD, 0, 'hFFFF, 'h0001, 'h0000, 32'h0000_0000, 1,
              {1'b1, 16'h0001, 16'h0000, 32'h0000_0000});
      add_row(KIND_SAMPLE, 0, 'hFFFF, 'h0000, 'h0100, 32'h0000_0001, 0, '0);
      add_row(KIND_LOAD, 1, 'h0000, 'h8000, 'h5A5A, 32'hA5A5_A5A5, 1,
              {1'b1, 16'h8000, 16'h0000, 32'h0000_0000});
      add_row(KIND_SAMPLE, 6, 'h0000, 'h7FFF, 'h0001, 32'h7FFF_FFFF, 0, '0);
      add_row(KIND_SAMPLE, 7, 'hFFFE, 'hFFFF, 'hFFFF, 32'hFFFF_FFFF, 1, '0);

      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= KIND_LOAD;
      send_burst = 1'b0;
      wait (!reset);
      @(negedge clock);

      for (n = 0; n < table_rows.size() + RANDOM_ITEMS; n++) begin
         if (n < table_rows.size()) begin
            rd = table_rows[n];
         end else begin
            rd.kind  = ($urandom_range(0, 99) < 4) ? KIND_LOAD : KIND_SAMPLE;
            rd.slot  = SLOT_FIELD_W'($urandom_range(0, SLOT_COUNT - 1));
            rd.room  = ID_W'($urandom);
            rd.stamp = $urandom;
            pick = $urandom_range(0, 9);
            rd.temp = (pick == 0) ? 16'h7FFF : (pick == 1) ? 16'h8000 : 16'($urandom);
            pick = $urandom_range(0, 9);
            if (rd.kind == KIND_LOAD)
               rd.sensor = (pick < 5) ? 16'($urandom_range(0, 15)) : 16'($urandom);
            else if (pick < 4)
               rd.sensor = slot_sensor[$urandom_range(0, 3)];
            else if (pick < 7)
               rd.sensor = slot_sensor[$urandom_range(0, SLOT_COUNT - 1)];
            else if (pick < 8)
               rd.sensor = ID_W'($urandom_range(0, 15));
            else
               rd.sensor = ID_W'($urandom);
         end

         if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
         gap = send_burst ? 0 : $urandom_range(0, 19);
         if (n == PAUSE_AT && gap == 0) gap = 1;
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            if (n == PAUSE_AT)
               while (predicted_reports.size() != 0) @(negedge clock);
            repeat (gap) @(negedge clock);
         end

         word = '0;
         word[REQ_SLOT_LO +: SLOT_FIELD_W] = rd.slot;
         word[REQ_SID_LO  +: ID_W]         = rd.sensor;
         word[REQ_RID_LO  +: ID_W]         = rd.room;
         word[REQ_TEMP_LO +: TEMP_W]       = rd.temp;
         word[REQ_TIME_LO +: TIME_W]       = rd.stamp;
         req_tvalid <= 1'b1;
         req_tuser  <= rd.kind;
         req_tdata  <= word;
         do @(posedge clock); while (!req_tready);

         res = update_sensor_table(rd);
         if (n < table_rows.size() && row_typed[n]) res = row_result[n];
         predicted_reports.push_back(res);
         @(negedge clock);
      end

      req_tvalid <= 1'b0;
      while (predicted_reports.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (report_errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/swat_pkg.sv
hdl/swat_match.sv
hdl/swat_divide.sv
hdl/sensor_window_average_table.sv
dv/sensor_window_average_table_tb.sv
